[design/vdr_pkg.sv]
// vdr_pkg: shared types and constants of the vertex weld block
// depends on nothing; used by every module of the block
`default_nettype none

package vdr_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int HASH_SLOTS   = 8192;
    localparam int IDX_W        = 12;
    localparam int VADDR_W      = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES) + 1;
    localparam int SLOT_W       = $clog2(HASH_SLOTS);
    localparam int VTX_W        = 256;

    localparam logic [63:0] HASH_IV    = 64'h243F6A8885A308D3;
    localparam logic [63:0] HASH_MUL   = 64'h9E3779B97F4A7C15;
    localparam int          HASH_SHIFT = 29;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMAP  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [31:0]      pos_x;
        logic [31:0]      pos_y;
        logic [31:0]      pos_z;
        logic [31:0]      nrm_x;
        logic [31:0]      nrm_y;
        logic [31:0]      nrm_z;
        logic [31:0]      tex_u;
        logic [31:0]      tex_v;
        logic [IDX_W-1:0] original_index;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] unique_index;
        logic             is_new;
        logic             error;
    } t_out;

    typedef struct packed {
        logic [1:0]        mode;
        logic [VTX_W-1:0]  vtx;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  oi;
    } t_cmd;

    typedef struct packed {
        logic             clearing;
        logic [CNT_W-1:0] input_count;
        logic [CNT_W-1:0] unique_count;
    } t_bk_status;

endpackage

`default_nettype wire

[design/vdr_front.sv]
// vdr_front: accepts words, hashes vertices with one shared 32x32 multiplier
// depends on vdr_pkg
`default_nettype none

module vdr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  vdr_pkg::t_in  i_in,
    output logic          o_in_ready,
    output logic          o_push,
    output vdr_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import vdr_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} t_fstate;
    typedef enum logic [2:0] {PH_XOR, PH_MUL_LL, PH_MUL_LH, PH_MUL_HL, PH_MIX} t_phase;

    t_fstate     r_state;
    t_phase      r_ph;
    t_cmd        r_cmd;
    logic [63:0] r_h, r_x, r_p0;
    logic [31:0] r_p1, r_p2;
    logic [1:0]  r_wi;

    logic [63:0] cur_w, mul_p, n_m, n_h;
    logic [31:0] mul_a, mul_b;
    logic [31:0] hi_sum;

    assign cur_w  = r_cmd.vtx[{~r_wi, 6'b0} +: 64];
    assign hi_sum = r_p1 + r_p2;
    assign n_m    = r_p0 + {hi_sum, 32'b0};
    assign n_h    = n_m ^ (n_m >> HASH_SHIFT);

    always_comb begin
        case (r_ph)
            PH_MUL_LH: begin
                mul_a = r_x[31:0];
                mul_b = HASH_MUL[63:32];
            end
            PH_MUL_HL: begin
                mul_a = r_x[63:32];
                mul_b = HASH_MUL[31:0];
            end
            default: begin
                mul_a = r_x[31:0];
                mul_b = HASH_MUL[31:0];
            end
        endcase
    end

    assign mul_p      = 64'(mul_a) * 64'(mul_b);
    assign o_in_ready = (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_ph    <= PH_XOR;
            r_wi    <= 2'd0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd.mode <= i_in.mode;
                        r_cmd.vtx  <= {i_in.pos_x, i_in.pos_y, i_in.pos_z, i_in.nrm_x,
                                       i_in.nrm_y, i_in.nrm_z, i_in.tex_u, i_in.tex_v};
                        r_cmd.oi   <= i_in.original_index;
                        r_cmd.slot <= '0;
                        r_h        <= HASH_IV;
                        r_wi       <= 2'd0;
                        r_ph       <= PH_XOR;
                        r_state    <= (i_in.mode == MODE_INSERT) ? F_HASH : F_PUSH;
                    end
                end
                F_HASH: begin
                    case (r_ph)
                        PH_XOR: begin
                            r_x  <= r_h ^ cur_w;
                            r_ph <= PH_MUL_LL;
                        end
                        PH_MUL_LL: begin
                            r_p0 <= mul_p;
                            r_ph <= PH_MUL_LH;
                        end
                        PH_MUL_LH: begin
                            r_p1 <= mul_p[31:0];
                            r_ph <= PH_MUL_HL;
                        end
                        PH_MUL_HL: begin
                            r_p2 <= mul_p[31:0];
                            r_ph <= PH_MIX;
                        end
                        default: begin
                            r_h  <= n_h;
                            r_ph <= PH_XOR;
                            r_wi <= r_wi + 2'd1;
                            if (r_wi == 2'd3) begin
                                // power-of-two table: modulo is the low bits
                                r_cmd.slot <= n_h[SLOT_W-1:0];
                                r_state    <= F_PUSH;
                            end
                        end
                    endcase
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/vdr_fifo.sv]
// vdr_fifo: two-entry command queue between front and back
// depends on vdr_pkg
`default_nettype none

module vdr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vdr_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output vdr_pkg::t_cmd o_data
);
    import vdr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

[design/vdr_back.sv]
// vdr_back: probes the slot table, compares stored vertices, keeps remap table
// depends on vdr_pkg
`default_nettype none

module vdr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  vdr_pkg::t_cmd       i_q,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vdr_pkg::t_out       o_out,
    output vdr_pkg::t_bk_status o_status
);
    import vdr_pkg::*;

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_SLOT, B_VTX, B_REMAP} t_bstate;

    localparam t_out OUT_ERR  = '{unique_index: '0, is_new: 1'b0, error: 1'b1};
    localparam t_out OUT_ZERO = '{unique_index: '0, is_new: 1'b0, error: 1'b0};

    // slot entry: valid bit over the unique index
    logic [VADDR_W:0]   slot_mem  [HASH_SLOTS];
    logic [VTX_W-1:0]   vtx_mem   [MAX_VERTICES];
    logic [VADDR_W-1:0] remap_mem [MAX_VERTICES];

    t_bstate            r_state;
    t_cmd               r_cmd;
    t_out               r_out;
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_slot, r_probes, r_clr;
    logic [CNT_W-1:0]   r_ic, r_uc;
    logic [VADDR_W:0]   r_slot_rd;
    logic [VTX_W-1:0]   r_vtx_rd;
    logic [VADDR_W-1:0] r_remap_rd;

    logic               slot_we, vtx_we, remap_we;
    logic [SLOT_W-1:0]  slot_raddr, slot_waddr;
    logic [VADDR_W:0]   slot_wdata;
    logic [VADDR_W-1:0] remap_wdata;
    logic               slot_empty, store_full, vtx_hit;

    assign o_pop       = (r_state == B_IDLE) && i_q_valid && !r_out_valid;
    assign slot_empty  = !r_slot_rd[VADDR_W];
    assign store_full  = (r_uc >= CNT_W'(MAX_VERTICES));
    assign vtx_hit     = (r_vtx_rd == r_cmd.vtx);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_status    = '{clearing: (r_state == B_CLEAR), input_count: r_ic,
                           unique_count: r_uc};

    always_comb begin
        slot_raddr  = r_slot;
        slot_we     = 1'b0;
        slot_waddr  = r_slot;
        slot_wdata  = {1'b1, r_uc[VADDR_W-1:0]};
        vtx_we      = 1'b0;
        remap_we    = 1'b0;
        remap_wdata = r_uc[VADDR_W-1:0];
        case (r_state)
            B_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                slot_wdata = '0;
            end
            B_IDLE: begin
                slot_raddr = i_q.slot;
            end
            B_SLOT: begin
                if (slot_empty && !store_full) begin
                    slot_we  = 1'b1;
                    vtx_we   = 1'b1;
                    remap_we = 1'b1;
                end
            end
            B_VTX: begin
                slot_raddr  = r_slot + 1'b1;
                remap_wdata = r_slot_rd[VADDR_W-1:0];
                remap_we    = vtx_hit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_rd <= slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (vtx_we) begin
            vtx_mem[r_uc[VADDR_W-1:0]] <= r_cmd.vtx;
        end
        r_vtx_rd <= vtx_mem[r_slot_rd[VADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (remap_we) begin
            remap_mem[r_ic[VADDR_W-1:0]] <= remap_wdata;
        end
        r_remap_rd <= remap_mem[i_q.oi[VADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_ic        <= '0;
            r_uc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SLOT_W'(HASH_SLOTS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_pop) begin
                        r_cmd    <= i_q;
                        r_slot   <= i_q.slot;
                        r_probes <= '0;
                        case (i_q.mode)
                            MODE_INSERT: begin
                                if (r_ic >= CNT_W'(MAX_VERTICES)) begin
                                    r_out       <= OUT_ERR;
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= B_SLOT;
                                end
                            end
                            MODE_REMAP: begin
                                if (CNT_W'(i_q.oi) < r_ic) begin
                                    r_state <= B_REMAP;
                                end else begin
                                    r_out       <= OUT_ERR;
                                    r_out_valid <= 1'b1;
                                end
                            end
                            MODE_CLEAR: begin
                                r_out       <= OUT_ZERO;
                                r_out_valid <= 1'b1;
                                r_ic        <= '0;
                                r_uc        <= '0;
                                r_clr       <= '0;
                                r_state     <= B_CLEAR;
                            end
                            default: begin
                                r_out       <= OUT_ERR;
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                B_SLOT: begin
                    if (slot_empty) begin
                        if (store_full) begin
                            r_out <= OUT_ERR;
                        end else begin
                            r_out <= '{unique_index: IDX_W'(r_uc), is_new: 1'b1,
                                       error: 1'b0};
                            r_uc  <= r_uc + 1'b1;
                            r_ic  <= r_ic + 1'b1;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end else begin
                        r_state <= B_VTX;
                    end
                end
                B_VTX: begin
                    if (vtx_hit) begin
                        r_out       <= '{unique_index: IDX_W'(r_slot_rd[VADDR_W-1:0]),
                                         is_new: 1'b0, error: 1'b0};
                        r_out_valid <= 1'b1;
                        r_ic        <= r_ic + 1'b1;
                        r_state     <= B_IDLE;
                    end else if (r_probes == SLOT_W'(HASH_SLOTS - 1)) begin
                        r_out       <= OUT_ERR;
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end else begin
                        r_probes <= r_probes + 1'b1;
                        r_slot   <= r_slot + 1'b1;
                        r_state  <= B_SLOT;
                    end
                end
                B_REMAP: begin
                    r_out       <= '{unique_index: IDX_W'(r_remap_rd), is_new: 1'b0,
                                     error: 1'b0};
                    r_out_valid <= 1'b1;
                    r_state     <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/vertex_dedup_remap.sv]
// vertex_dedup_remap: an insert with no hash collision is hashed in the front, five steps
// per 64-bit word (XOR, three products on one shared 32x32 multiplier, mix), then pushed
// to the queue, popped and probed; each extra probe adds a slot read and a vertex compare.
// A clear word gives its result and then sweeps the slot table. The front takes no new word
// until it has pushed the last. After reset the slot table is swept; words are accepted
// meanwhile but results wait until it ends.
`default_nettype none

module vertex_dedup_remap (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  vdr_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output vdr_pkg::t_out o_out
);
    import vdr_pkg::*;

    // front to queue
    logic       push, full;
    t_cmd       push_cmd;
    // queue to back
    logic       q_valid, pop;
    t_cmd       q_cmd;
    t_bk_status status;

    // front: latches the word and hashes insert vertices
    vdr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (full)
    );

    // short queue decouples hashing from probing
    vdr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // back: linear probing, vertex store, remap table, output register
    vdr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q         (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_status    (status)
    );

    // an error word never carries an index or a new flag
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.error) |-> (o_out.unique_index == '0 && !o_out.is_new))
        else $error("error word carries index or new flag");

    // every stored vertex came from an inserted word
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.unique_count <= status.input_count)
        else $error("unique count above input count");

    // input count never passes the table size
    a_ic_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.input_count <= CNT_W'(MAX_VERTICES))
        else $error("input count overflow");

    // a new index advances the unique count by one
    a_new_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && o_out.is_new)
            |-> (status.unique_count == $past(status.unique_count) + 1'b1))
        else $error("new index without count step");

endmodule

`default_nettype wire
